// ===== rtl/rlfe_pkg.sv =====
// Package for the RGB(W) LED fade envelope core.
// Holds the field widths, register indexes, opcodes and the beat structs.
// No dependencies.
package rlfe_pkg;

    localparam int TIME_BITS_DEF = 16;
    localparam int COLOUR_W      = 8;
    localparam int LEVEL_W       = 7;
    localparam int DELTA_W       = 8;
    localparam int PCT_W         = 7;
    localparam int CHAN_Q_W      = 9;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_TIME_W    = 16;

    localparam logic [PCT_W-1:0]    PCT        = 7'd100;
    localparam logic [COLOUR_W-1:0] COLOUR_MAX = 8'hFF;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BASE_RED   = 3'd0,
        REG_BASE_GREEN = 3'd1,
        REG_BASE_BLUE  = 3'd2,
        REG_MAX_LEVEL  = 3'd3,
        REG_RISE_TIME  = 3'd4,
        REG_FALL_TIME  = 3'd5,
        REG_WHITE_MODE = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic               opcode;
        logic [DELTA_W-1:0] tick_delta;
    } item_t;

    typedef struct packed {
        logic [COLOUR_W-1:0] red_out;
        logic [COLOUR_W-1:0] green_out;
        logic [COLOUR_W-1:0] blue_out;
        logic [COLOUR_W-1:0] white_out;
        logic                fading;
    } result_t;

endpackage

// ===== rtl/rlfe_muldiv.sv =====
// Bit-serial multiply then divide unit: q = (a * b) / d, one bit per cycle.
// Shift-add multiply over the B_W bits of b, then restoring division giving Q_W quotient bits.
// No dependencies; the quotient must fit in Q_W bits.
module rlfe_muldiv #(
    parameter int A_W = 8,
    parameter int B_W = 7,
    parameter int D_W = 7,
    parameter int Q_W = 9
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    input  logic [D_W-1:0] d,
    output logic           done,
    output logic [Q_W-1:0] q
);

    localparam int P_W   = A_W + B_W;
    localparam int DS_W  = D_W + Q_W - 1;
    localparam int W     = (P_W > DS_W) ? P_W : DS_W;
    localparam int N_MAX = (B_W > Q_W) ? B_W : Q_W;
    localparam int CNT_W = (N_MAX > 2) ? $clog2(N_MAX) : 1;

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_MUL  = 3'b010,
        MD_DIV  = 3'b100
    } md_state_t;

    md_state_t        state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [W-1:0]     acc_reg;
    logic [W-1:0]     ash_reg;
    logic [B_W-1:0]   bsh_reg;
    logic [W-1:0]     dsh_reg;
    logic [Q_W-1:0]   q_reg;
    logic             ge;

    assign ge   = (acc_reg >= dsh_reg);
    assign done = done_reg;
    assign q    = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                MD_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= MD_MUL;
                        cnt_reg   <= CNT_W'(B_W - 1);
                    end
                end
                MD_MUL:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= MD_DIV;
                        cnt_reg   <= CNT_W'(Q_W - 1);
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                MD_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= MD_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= MD_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    acc_reg <= '0;
                    ash_reg <= W'(a);
                    bsh_reg <= b;
                    dsh_reg <= W'(d) << (Q_W - 1);
                end
            end
            MD_MUL:
            begin
                if (bsh_reg[0])
                begin
                    acc_reg <= acc_reg + ash_reg;
                end
                ash_reg <= ash_reg << 1;
                bsh_reg <= bsh_reg >> 1;
            end
            MD_DIV:
            begin
                if (ge)
                begin
                    acc_reg <= acc_reg - dsh_reg;
                end
                q_reg   <= {q_reg[Q_W-2:0], ge};
                dsh_reg <= dsh_reg >> 1;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

endmodule

// ===== rtl/rgb_led_fade_envelope_core.sv =====
// Top level of the RGB(W) LED fade envelope core.
// Depends on rlfe_pkg and rlfe_muldiv.
//
// A start beat latches colour, peak level, fade times and white mode from the
// configuration registers and loads the rise and fall counters; a tick beat
// counts the rise counter down and then the fall counter, saturating at zero,
// and one result beat follows every item. A tick that changes the level
// passes through the level unit (multiply by the peak level and divide by the
// fade time, one bit per cycle), then the three channel units (multiply by
// the level and divide by one hundred). A start uses only the channel units
// and a tick while idle uses neither. Items are handled one at a time; the
// result register lets the next item in while a result awaits its taker.
module rgb_led_fade_envelope_core #(
    parameter int TIME_BITS = rlfe_pkg::TIME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  rlfe_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output rlfe_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rlfe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rlfe_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = rlfe_pkg::COLOUR_W;
    localparam int LW = rlfe_pkg::LEVEL_W;
    localparam int QW = rlfe_pkg::CHAN_Q_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LEVEL = 4'b0010,
        ST_CHAN  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg;

    logic [CW-1:0]                   base_red_reg;
    logic [CW-1:0]                   base_green_reg;
    logic [CW-1:0]                   base_blue_reg;
    logic [LW-1:0]                   max_level_reg;
    logic [rlfe_pkg::CFG_TIME_W-1:0] rise_time_reg;
    logic [rlfe_pkg::CFG_TIME_W-1:0] fall_time_reg;
    logic                            white_mode_reg;

    logic [CW-1:0]        lat_r_reg;
    logic [CW-1:0]        lat_g_reg;
    logic [CW-1:0]        lat_b_reg;
    logic [LW-1:0]        lat_lvl_reg;
    logic                 lat_white_reg;
    logic [TIME_BITS-1:0] rise_base_reg;
    logic [TIME_BITS-1:0] fall_base_reg;
    logic [TIME_BITS-1:0] rise_left_reg;
    logic [TIME_BITS-1:0] fall_left_reg;
    logic                 rising_reg;

    logic [CW-1:0] red_now_reg;
    logic [CW-1:0] green_now_reg;
    logic [CW-1:0] blue_now_reg;
    logic [CW-1:0] white_now_reg;

    logic              result_valid_reg;
    rlfe_pkg::result_t result_reg;

    logic                 accept;
    logic                 is_start;
    logic                 rise_act;
    logic                 fall_act;
    logic [TIME_BITS-1:0] delta_ext;
    logic [TIME_BITS-1:0] rise_sub;
    logic [TIME_BITS-1:0] fall_sub;
    logic [TIME_BITS-1:0] rise_trunc;
    logic [TIME_BITS-1:0] fall_trunc;

    logic                 lvl_start;
    logic [TIME_BITS-1:0] lvl_a;
    logic [TIME_BITS-1:0] lvl_d;
    logic                 lvl_done;
    logic [LW-1:0]        lvl_q;

    logic          chan_start;
    logic [LW-1:0] chan_level;
    logic [CW-1:0] chan_a [3];
    logic [2:0]    chan_done;
    logic [QW-1:0] chan_q [3];
    logic [CW-1:0] sat [3];
    logic [CW-1:0] min_c;
    logic          emit_go;

    assign cfg_ready    = 1'b1;
    assign item_ready   = (state_reg == ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign is_start     = (item.opcode == rlfe_pkg::OP_START);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign delta_ext  = TIME_BITS'(item.tick_delta);
    assign rise_sub   = (rise_left_reg > delta_ext) ? rise_left_reg - delta_ext : '0;
    assign fall_sub   = (fall_left_reg > delta_ext) ? fall_left_reg - delta_ext : '0;
    assign rise_trunc = TIME_BITS'(rise_time_reg);
    assign fall_trunc = TIME_BITS'(fall_time_reg);
    assign rise_act   = (rise_left_reg != '0) && (rise_base_reg != '0);
    assign fall_act   = (fall_left_reg != '0) && (fall_base_reg != '0);

    assign lvl_start = accept && !is_start && (rise_act || fall_act);
    assign lvl_a     = rise_act ? rise_sub : fall_sub;
    assign lvl_d     = rise_act ? rise_base_reg : fall_base_reg;

    assign chan_start = (accept && is_start) || ((state_reg == ST_LEVEL) && lvl_done);

    always_comb
    begin
        if (state_reg == ST_LEVEL)
        begin
            chan_level = rising_reg ? (lat_lvl_reg - lvl_q) : lvl_q;
            chan_a[0]  = lat_r_reg;
            chan_a[1]  = lat_g_reg;
            chan_a[2]  = lat_b_reg;
        end
        else
        begin
            chan_level = (rise_trunc == '0) ? max_level_reg : '0;
            chan_a[0]  = base_red_reg;
            chan_a[1]  = base_green_reg;
            chan_a[2]  = base_blue_reg;
        end
    end

    rlfe_muldiv #(
        .A_W (TIME_BITS),
        .B_W (LW),
        .D_W (TIME_BITS),
        .Q_W (LW)
    ) u_level (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lvl_start),
        .a     (lvl_a),
        .b     (lat_lvl_reg),
        .d     (lvl_d),
        .done  (lvl_done),
        .q     (lvl_q)
    );

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        rlfe_muldiv #(
            .A_W (CW),
            .B_W (LW),
            .D_W (rlfe_pkg::PCT_W),
            .Q_W (QW)
        ) u_chan (
            .clk   (clk),
            .rst_n (rst_n),
            .start (chan_start),
            .a     (chan_a[c]),
            .b     (chan_level),
            .d     (rlfe_pkg::PCT),
            .done  (chan_done[c]),
            .q     (chan_q[c])
        );

        assign sat[c] = (chan_q[c] > QW'(rlfe_pkg::COLOUR_MAX)) ?
                        rlfe_pkg::COLOUR_MAX : chan_q[c][CW-1:0];
    end

    always_comb
    begin
        min_c = sat[0];
        if (min_c > sat[2])
        begin
            min_c = sat[2];
        end
        if (min_c > sat[1])
        begin
            min_c = sat[1];
        end
    end

    assign emit_go = (state_reg == ST_EMIT) && (!result_valid_reg || result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_red_reg   <= rlfe_pkg::COLOUR_MAX;
            base_green_reg <= rlfe_pkg::COLOUR_MAX;
            base_blue_reg  <= rlfe_pkg::COLOUR_MAX;
            max_level_reg  <= rlfe_pkg::PCT;
            rise_time_reg  <= '0;
            fall_time_reg  <= '0;
            white_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rlfe_pkg::REG_BASE_RED:   base_red_reg   <= cfg_data[CW-1:0];
                rlfe_pkg::REG_BASE_GREEN: base_green_reg <= cfg_data[CW-1:0];
                rlfe_pkg::REG_BASE_BLUE:  base_blue_reg  <= cfg_data[CW-1:0];
                rlfe_pkg::REG_MAX_LEVEL:  max_level_reg  <= cfg_data[LW-1:0];
                rlfe_pkg::REG_RISE_TIME:  rise_time_reg  <= cfg_data;
                rlfe_pkg::REG_FALL_TIME:  fall_time_reg  <= cfg_data;
                rlfe_pkg::REG_WHITE_MODE: white_mode_reg <= cfg_data[0];
                default:                  white_mode_reg <= white_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            lat_r_reg        <= '0;
            lat_g_reg        <= '0;
            lat_b_reg        <= '0;
            lat_lvl_reg      <= '0;
            lat_white_reg    <= 1'b0;
            rise_base_reg    <= '0;
            fall_base_reg    <= '0;
            rise_left_reg    <= '0;
            fall_left_reg    <= '0;
            rising_reg       <= 1'b0;
            red_now_reg      <= '0;
            green_now_reg    <= '0;
            blue_now_reg     <= '0;
            white_now_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && is_start)
                    begin
                        lat_r_reg     <= base_red_reg;
                        lat_g_reg     <= base_green_reg;
                        lat_b_reg     <= base_blue_reg;
                        lat_lvl_reg   <= max_level_reg;
                        lat_white_reg <= white_mode_reg;
                        rise_base_reg <= rise_trunc;
                        fall_base_reg <= fall_trunc;
                        rise_left_reg <= rise_trunc;
                        fall_left_reg <= fall_trunc;
                        state_reg     <= ST_CHAN;
                    end
                    else if (accept)
                    begin
                        if (rise_act)
                        begin
                            rise_left_reg <= rise_sub;
                            rising_reg    <= 1'b1;
                            state_reg     <= ST_LEVEL;
                        end
                        else if (fall_act)
                        begin
                            fall_left_reg <= fall_sub;
                            rising_reg    <= 1'b0;
                            state_reg     <= ST_LEVEL;
                        end
                        else
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_LEVEL:
                begin
                    if (lvl_done)
                    begin
                        state_reg <= ST_CHAN;
                    end
                end
                ST_CHAN:
                begin
                    if (&chan_done)
                    begin
                        if (lat_white_reg)
                        begin
                            red_now_reg   <= sat[0] - min_c;
                            green_now_reg <= sat[1] - min_c;
                            blue_now_reg  <= sat[2] - min_c;
                            white_now_reg <= min_c;
                        end
                        else
                        begin
                            red_now_reg   <= sat[0];
                            green_now_reg <= sat[1];
                            blue_now_reg  <= sat[2];
                            white_now_reg <= '0;
                        end
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        result_valid_reg <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            result_reg.red_out   <= red_now_reg;
            result_reg.green_out <= green_now_reg;
            result_reg.blue_out  <= blue_now_reg;
            result_reg.white_out <= white_now_reg;
            result_reg.fading    <= (rise_left_reg != '0) || (fall_left_reg != '0);
        end
    end

endmodule
